// ===== sv/upie_pkg.sv =====
// ----------------------------------------------------------------------------
// upie_pkg
// Shared types, codes and helpers for the unaligned PER integer encoder.
// ----------------------------------------------------------------------------
package upie_pkg;

  // field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned OCTN_W   = 4;
  localparam int unsigned SMALL_W  = 6;
  localparam int unsigned IN_TDATA_W  = 3 * VAL_W;
  localparam int unsigned OUT_TDATA_W = 72;

  // chunk lengths for the fixed-size chunks
  localparam logic [LEN_W-1:0] SMALL_LEN   = 7'd7;
  localparam logic [LEN_W-1:0] LENOCT_LEN  = 7'd8;
  localparam logic [LEN_W-1:0] FLAGOCT_LEN = 7'd9;

  // encoding modes carried in tuser
  localparam logic [ACT_W-1:0] ACT_CONSTRAINED = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SMALL       = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNCON       = 2'd2;

  // operands after the first stage
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] diff;
    logic [VAL_W-1:0] range;
  } prep_t;

  // one or two chunks of one item
  typedef struct packed {
    logic [VAL_W-1:0] data0;
    logic [LEN_W-1:0] len0;
    logic [VAL_W-1:0] data1;
    logic [LEN_W-1:0] len1;
    logic             two;
  } chunk_pair_t;

  // ones in the low len bits, len in 0..64
  function automatic logic [VAL_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [VAL_W-1:0] m;
    m = '0;
    for (int i = 0; i < VAL_W; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

endpackage

// ===== sv/upie_prep.sv =====
// ----------------------------------------------------------------------------
// upie_prep
// Input register: takes one item and forms value - lower and upper - lower.
// ----------------------------------------------------------------------------
module upie_prep
  import upie_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  logic [VAL_W-1:0] in_value,
  input  logic [VAL_W-1:0] in_lower,
  input  logic [VAL_W-1:0] in_upper,
  output logic             out_valid,
  input  logic             out_ready,
  output prep_t            out_item
);

  logic  valid;
  prep_t item;

  // stage moves when empty or when the next stage takes the item
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // control and payload registers, wrapped 64-bit differences
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item.action <= in_action;
      item.value  <= in_value;
      item.diff   <= in_value - in_lower;
      item.range  <= in_upper - in_lower;
    end
  end

endmodule

// ===== sv/upie_enc.sv =====
// ----------------------------------------------------------------------------
// upie_enc
// Chunk former: bit length of the range, octet count, masking per mode.
// ----------------------------------------------------------------------------
module upie_enc
  import upie_pkg::*;
(
  input  prep_t       item,
  output chunk_pair_t pair
);

  logic [LEN_W-1:0]  range_bits;
  logic [VAL_W-1:0]  mag;
  logic [OCTN_W-1:0] octn;
  logic [LEN_W-1:0]  data_len;
  logic              is_small;

  // position of the highest set bit of the range, plus one
  always_comb begin
    range_bits = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (item.range[i]) begin
        range_bits = LEN_W'(i + 1);
      end
    end
  end

  // minimal two's-complement octet count, 1..8
  always_comb begin
    mag  = item.value[VAL_W-1] ? ~item.value : item.value;
    octn = OCTN_W'(1);
    for (int k = 1; k < 8; k++) begin
      if ((mag >> (8 * k - 1)) != '0) begin
        octn = OCTN_W'(k + 1);
      end
    end
  end

  assign data_len = LEN_W'({octn, 3'b000});
  assign is_small = (item.value[VAL_W-1:SMALL_W] == '0);

  // chunk selection per mode
  always_comb begin
    pair.data1 = item.value & low_mask(data_len);
    pair.len1  = data_len;
    pair.two   = 1'b1;
    case (item.action)
      ACT_CONSTRAINED: begin
        pair.data0 = item.diff & low_mask(range_bits);
        pair.len0  = range_bits;
        pair.two   = 1'b0;
      end
      ACT_SMALL: begin
        if (is_small) begin
          pair.data0 = VAL_W'(item.value[SMALL_W-1:0]);
          pair.len0  = SMALL_LEN;
          pair.two   = 1'b0;
        end else begin
          pair.data0 = VAL_W'({1'b1, 4'b0000, octn});
          pair.len0  = FLAGOCT_LEN;
        end
      end
      default: begin
        pair.data0 = VAL_W'({4'b0000, octn});
        pair.len0  = LENOCT_LEN;
      end
    endcase
  end

endmodule

// ===== sv/upie_out.sv =====
// ----------------------------------------------------------------------------
// upie_out
// Result register: holds one item's chunks and sends them one per beat.
// ----------------------------------------------------------------------------
module upie_out
  import upie_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  chunk_pair_t      in_pair,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_data,
  output logic [LEN_W-1:0] out_len,
  output logic             out_last
);

  logic        valid;
  logic        phase;
  chunk_pair_t pair;

  // second chunk follows only for two-chunk items
  assign out_last  = !pair.two || phase;
  assign out_valid = valid;
  assign out_data  = phase ? pair.data1 : pair.data0;
  assign out_len   = phase ? pair.len1  : pair.len0;
  assign in_ready  = !valid || (out_ready && out_last);

  // load a new pair once the last chunk leaves, else step to the second chunk
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
      phase <= 1'b0;
    end else if (out_ready) begin
      phase <= 1'b1;
    end
    if (in_valid && in_ready) begin
      pair <= in_pair;
    end
  end

endmodule

// ===== sv/uper_integer_encoder.sv =====
// An accepted item is held in the input register, passes the combinational
// chunk former and is registered in the result register, from which its
// chunks leave. One item per cycle is taken when it gives a single chunk and
// the result port does not stall; an item with a length chunk and a data chunk
// blocks new items until its data chunk has left the single result channel.
// Reset clears the valid bits of both pipeline registers; the data is not reset.
// ----------------------------------------------------------------------------
// uper_integer_encoder
// Unaligned PER integer encoder: constrained, normally-small, unconstrained.
// ----------------------------------------------------------------------------
module uper_integer_encoder
  import upie_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // value, lower_bound, upper_bound
  input  logic [ACT_W-1:0]       s_axis_tuser,  // action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // chunk_data, chunk_length, zero pad
  output logic                   m_axis_tlast   // last_chunk
);

  logic             prep_valid;
  logic             out_ready;
  prep_t            prep_item;
  chunk_pair_t      pair;
  logic [VAL_W-1:0] chunk_data;
  logic [LEN_W-1:0] chunk_length;

  // input register and subtractors
  upie_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_value  (s_axis_tdata[VAL_W-1:0]),
    .in_lower  (s_axis_tdata[2*VAL_W-1:VAL_W]),
    .in_upper  (s_axis_tdata[3*VAL_W-1:2*VAL_W]),
    .out_valid (prep_valid),
    .out_ready (out_ready),
    .out_item  (prep_item)
  );

  // chunk forming
  upie_enc u_enc (
    .item (prep_item),
    .pair (pair)
  );

  // result register and chunk sequencing
  upie_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (out_ready),
    .in_pair   (pair),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (chunk_data),
    .out_len   (chunk_length),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, chunk_length, chunk_data};

endmodule

// ===== sv/upie_checker.sv =====
// ----------------------------------------------------------------------------
// upie_checker
// Port-level checks of the encoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module upie_checker
  import upie_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  logic [VAL_W-1:0] chunk_data;
  logic [LEN_W-1:0] chunk_length;

  assign chunk_data   = m_axis_tdata[VAL_W-1:0];
  assign chunk_length = m_axis_tdata[VAL_W+LEN_W-1:VAL_W];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // bits above the chunk length are zero
  a_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (chunk_length < LEN_W'(VAL_W)) |->
      ((chunk_data >> chunk_length) == '0))
    else $error("chunk has bits above its length");

  // a chunk that is not the last is a length octet, with or without flag
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      (chunk_length == LENOCT_LEN || chunk_length == FLAGOCT_LEN))
    else $error("leading chunk has wrong length");

  // data chunk follows its length chunk at once, sized by the length octet
  a_follow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tlast &&
      (chunk_length == LEN_W'({$past(chunk_data[OCTN_W-1:0]), 3'b000})))
    else $error("data chunk missing or mis-sized after length chunk");

endmodule

bind uper_integer_encoder upie_checker u_upie_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/uper_integer_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// uper_integer_encoder_tb
// Self-checking bench for the unaligned PER integer encoder. Items go in
// through the input stream with random gaps, and the chunk stream sees random
// back-pressure. An encoding predictor written here queues the chunks each
// accepted item should give. Each chunk that leaves is checked against the
// oldest queued chunk.
// ----------------------------------------------------------------------------
module uper_integer_encoder_tb
  import upie_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // action 3 has no name in the package, the encoder treats it as unconstrained
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [VAL_W-1:0] data;
    logic [LEN_W-1:0] nbits;
    logic             last;
  } chunk_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [ACT_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  chunk_t expected_chunks[$];
  int     mismatch_count;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_cycles;

  uper_integer_encoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ones in the low w bits, w in 0..64
  function automatic logic [VAL_W-1:0] width_mask(input int w);
    if (w >= 64) begin
      return '1;
    end
    return (64'd1 << w) - 64'd1;
  endfunction

  // position of the highest set bit plus one
  function automatic int bits_needed(input logic [VAL_W-1:0] span);
    for (int i = VAL_W - 1; i >= 0; i--) begin
      if (span[i]) begin
        return i + 1;
      end
    end
    return 0;
  endfunction

  // minimal two's-complement octets, 1..8
  function automatic int octets_needed(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] t;
    int               n;
    t = v[VAL_W-1] ? ~v : v;
    n = 1;
    while (t > 64'h7F) begin
      t = t >> 8;
      n++;
    end
    return n;
  endfunction

  function automatic void queue_chunk(input logic [VAL_W-1:0] data, input int nbits,
                                      input logic last);
    chunk_t c;
    c.data  = data & width_mask(nbits);
    c.nbits = LEN_W'(nbits);
    c.last  = last;
    expected_chunks.push_back(c);
  endfunction

  // expected chunks of one accepted item
  function automatic void predict_encoding(input logic [ACT_W-1:0] action,
                                           input logic [VAL_W-1:0] value,
                                           input logic [VAL_W-1:0] lower,
                                           input logic [VAL_W-1:0] upper);
    int n;
    if (action == ACT_CONSTRAINED) begin
      queue_chunk(value - lower, bits_needed(upper - lower), 1'b1);
    end else if (action == ACT_SMALL && !value[VAL_W-1] && value < 64) begin
      queue_chunk(value, SMALL_LEN, 1'b1);
    end else begin
      n = octets_needed(value);
      if (action == ACT_SMALL) begin
        queue_chunk({55'd0, 1'b1, 8'(n)}, FLAGOCT_LEN, 1'b0);
      end else begin
        queue_chunk(64'(n), LENOCT_LEN, 1'b0);
      end
      queue_chunk(value, 8 * n, 1'b1);
    end
  endfunction

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // values biased toward the small range and the octet boundaries
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] b;
    int               sh;
    r = rand64();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 70));
      1: begin
        sh = $urandom_range(0, 63);
        return $signed(r << sh) >>> sh;
      end
      2: return r;
      3: begin
        b = 64'd1 << (8 * $urandom_range(1, 8) - 1);
        case ($urandom_range(0, 3))
          0: return b;
          1: return b - 64'd1;
          2: return -b;
          default: return -b - 64'd1;
        endcase
      end
      default: return -64'($urandom_range(1, 200));
    endcase
  endfunction

  // one item, predicted when accepted
  task automatic send_item(input logic [ACT_W-1:0] action, input logic [VAL_W-1:0] value,
                           input logic [VAL_W-1:0] lower, input logic [VAL_W-1:0] upper);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tdata  = {upper, lower, value};
    s_axis_tuser  = action;
    s_axis_tvalid = 1'b1;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    predict_encoding(action, value, lower, upper);
  endtask

  // sender pause until every chunk is out
  task automatic wait_all_chunks();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_constrained_edges();
    // single-value ranges
    send_item(ACT_CONSTRAINED, 64'd0, 64'd0, 64'd0);
    send_item(ACT_CONSTRAINED, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h8000_0000_0000_0000);
    // full range, both ways of spanning it
    send_item(ACT_CONSTRAINED, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'h7FFF_FFFF_FFFF_FFFF);
    send_item(ACT_CONSTRAINED, '1, 64'd0, '1);
    // value above the range
    send_item(ACT_CONSTRAINED, 64'd100, 64'd10, 64'd20);
    // inverted bounds
    send_item(ACT_CONSTRAINED, 64'd50, 64'd100, 64'd5);
    send_item(ACT_CONSTRAINED, -64'd5, -64'd5, 64'd5);
    send_item(ACT_CONSTRAINED, 64'd255, 64'd0, 64'd255);
  endtask

  task automatic test_normally_small_edges();
    send_item(ACT_SMALL, 64'd0, '1, 64'd0);
    send_item(ACT_SMALL, 64'd63, 64'd0, '1);
    send_item(ACT_SMALL, 64'd64, 64'd0, 64'd0);
    send_item(ACT_SMALL, '1, 64'd0, 64'd0);
    send_item(ACT_SMALL, 64'h8000_0000_0000_0000, 64'd0, 64'd0);
    send_item(ACT_SMALL, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
  endtask

  task automatic test_unconstrained_edges();
    send_item(ACT_UNCON, 64'd0, 64'd0, 64'd0);
    send_item(ACT_UNCON, 64'd127, 64'd0, 64'd0);
    send_item(ACT_UNCON, 64'd128, 64'd0, 64'd0);
    send_item(ACT_UNCON, -64'd128, 64'd0, 64'd0);
    send_item(ACT_UNCON, -64'd129, 64'd0, 64'd0);
    send_item(ACT_UNCON, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1);
    send_item(ACT_UNCON, 64'h8000_0000_0000_0000, '1, '1);
    // unused action code
    send_item(ACT_SPARE, 64'd255, '1, 64'd0);
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_all_chunks();
    hold_cycles = 150;
    for (int i = 0; i < 40; i++) begin
      send_item(ACT_UNCON, pick_value(), rand64(), rand64());
    end
    wait_all_chunks();
  endtask

  task automatic test_random_mix(input int count);
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    logic [VAL_W-1:0] span;
    int               pick;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(0, 99);
      value = pick_value();
      lower = rand64();
      upper = rand64();
      if (pick < 40) begin
        action = ACT_CONSTRAINED;
        lower  = pick_value();
        span   = rand64() & width_mask($urandom_range(0, 64));
        upper  = lower + span;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: value = lower + (rand64() & span);
          6, 7: value = pick_value();
          // bounds in any order
          8: begin
            upper = pick_value();
            value = lower + 64'($urandom_range(0, 300));
          end
          default: begin
            upper = lower;
            value = ($urandom_range(0, 1) != 0) ? lower : rand64();
          end
        endcase
      end else if (pick < 70) begin
        action = ACT_SMALL;
      end else if (pick < 95) begin
        action = ACT_UNCON;
      end else begin
        action = ACT_SPARE;
      end
      send_item(action, value, lower, upper);
    end
  endtask

  // receiver ready, long hold-off first when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles   = hold_cycles - 1;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each chunk with the oldest expected one
  always @(posedge clk) begin
    chunk_t exp_c;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_chunks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected chunk: data %h len %0d last %b", m_axis_tdata[63:0],
                   m_axis_tdata[70:64], m_axis_tlast);
        end
      end else begin
        exp_c = expected_chunks.pop_front();
        if (m_axis_tdata[63:0] !== exp_c.data || m_axis_tdata[70:64] !== exp_c.nbits ||
            m_axis_tlast !== exp_c.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("chunk mismatch: expected data %h len %0d last %b, got data %h len %0d last %b",
                     exp_c.data, exp_c.nbits, exp_c.last, m_axis_tdata[63:0],
                     m_axis_tdata[70:64], m_axis_tlast);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("uper_integer_encoder verification failed");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_cycles    = 0;
    send_idle_pct  = 15;
    recv_idle_pct  = 58;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_constrained_edges();
    test_normally_small_edges();
    test_unconstrained_edges();
    test_output_backpressure();
    test_random_mix(420);

    // idling the other way round
    send_idle_pct = 58;
    recv_idle_pct = 15;
    test_random_mix(420);

    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(410);

    wait_all_chunks();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_chunks.size() == 0) begin
      $display("uper_integer_encoder verification clean");
    end else begin
      $display("uper_integer_encoder verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/upie_pkg.sv
sv/upie_prep.sv
sv/upie_enc.sv
sv/upie_out.sv
sv/uper_integer_encoder.sv
sv/upie_checker.sv
bench/uper_integer_encoder_tb.sv
